>>> rtl/core/tlr_pkg.sv
// ----------------------------------------------------------------------------
// tlr_pkg
// Shared types and constants for the thick line rasterizer.
// ----------------------------------------------------------------------------
package tlr_pkg;

  localparam int unsigned TlrCoordBits   = 12;
  localparam int unsigned TlrMaxThick    = 7;

  localparam int unsigned FrameBits      = 12;
  localparam int unsigned ThickBits      = 3;
  localparam int unsigned ColourBits     = 8;
  localparam int unsigned IdxBits        = 24;
  localparam int unsigned CfgIdxBits     = 3;
  localparam int unsigned CfgDataBits    = 12;

  localparam logic [FrameBits-1:0]  RstFrameWidth  = 12'd320;
  localparam logic [FrameBits-1:0]  RstFrameHeight = 12'd240;
  localparam logic [ThickBits-1:0]  RstThickness   = 3'd2;
  localparam logic [ColourBits-1:0] RstRed         = 8'd0;
  localparam logic [ColourBits-1:0] RstGreen       = 8'd100;
  localparam logic [ColourBits-1:0] RstBlue        = 8'd255;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_PEN_THICK    = 3'd2,
    CFG_RED          = 3'd3,
    CFG_GREEN        = 3'd4,
    CFG_BLUE         = 3'd5
  } tlr_cfg_reg_e;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } tlr_cmd_e;

  typedef struct packed {
    logic [FrameBits-1:0]  width;
    logic [FrameBits-1:0]  height;
    logic [ThickBits-1:0]  thick;
    logic [ColourBits-1:0] red;
    logic [ColourBits-1:0] green;
    logic [ColourBits-1:0] blue;
  } tlr_cfg_t;

  // Hand-over from the step unit to the pen sequencer
  typedef struct packed {
    logic load;   // new point accepted this cycle
    logic empty;  // advance with no active line: single blank result
  } tlr_load_t;

endpackage

>>> rtl/core/thick_line_rasterizer.sv
// Order: an item is loaded into the step unit, then its results are registered.
// Results: (2*h+1)^2 per point, h = min(pen_thickness, MAX_THICKNESS)/2, in
// pen column-major order; an advance with no active line gives one result.
// Throughput: one result per cycle while m_axis_tready allows, set by the single
// pen sequencer; the next item is taken as the last result is registered.
// Reset: asynchronous, active low; all but the result data registers reset.
// ----------------------------------------------------------------------------
// thick_line_rasterizer
// Bresenham line walker with a square pen, producing frame buffer writes.
// ----------------------------------------------------------------------------
module thick_line_rasterizer #(
  parameter int unsigned COORD_BITS    = tlr_pkg::TlrCoordBits,
  parameter int unsigned MAX_THICKNESS = tlr_pkg::TlrMaxThick
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [tlr_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [tlr_pkg::CfgDataBits-1:0]     cfg_data_i,
  // command stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // start_x, start_y, finish_x, finish_y
  input  logic [((4*COORD_BITS)+7)/8*8-1:0]   s_axis_tdata,
  // command
  input  logic                                s_axis_tuser,
  // pixel stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pixel_x, pixel_y, byte_index, red, green, blue, zero pad
  output logic [((2*COORD_BITS)+2+48+7)/8*8-1:0] m_axis_tdata,
  // write_enable, line_done
  output logic [1:0]                          m_axis_tuser,
  // last_of_point
  output logic                                m_axis_tlast
);
  import tlr_pkg::*;

  localparam int unsigned PW       = COORD_BITS + 1;
  localparam int unsigned OutUsed  = 2 * PW + IdxBits + 3 * ColourBits;
  localparam int unsigned OutDataW = (OutUsed + 7) / 8 * 8;

  tlr_cfg_t  cfg_q;
  tlr_load_t ld;

  logic signed [COORD_BITS-1:0] cur_x, cur_y;
  logic                         done;
  logic                         take;

  logic signed [PW-1:0]       pixel_x, pixel_y;
  logic [IdxBits-1:0]         byte_index;
  logic [ColourBits-1:0]      red, green, blue;
  logic                       write_enable, last_of_point, line_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= RstFrameWidth;
      cfg_q.height <= RstFrameHeight;
      cfg_q.thick  <= RstThickness;
      cfg_q.red    <= RstRed;
      cfg_q.green  <= RstGreen;
      cfg_q.blue   <= RstBlue;
    end else if (cfg_we_i) begin
      case (tlr_cfg_reg_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:  cfg_q.width  <= cfg_data_i[FrameBits-1:0];
        CFG_FRAME_HEIGHT: cfg_q.height <= cfg_data_i[FrameBits-1:0];
        CFG_PEN_THICK:    cfg_q.thick  <= cfg_data_i[ThickBits-1:0];
        CFG_RED:          cfg_q.red    <= cfg_data_i[ColourBits-1:0];
        CFG_GREEN:        cfg_q.green  <= cfg_data_i[ColourBits-1:0];
        CFG_BLUE:         cfg_q.blue   <= cfg_data_i[ColourBits-1:0];
        default: ;
      endcase
    end
  end

  tlr_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid),
    .take_i     (take),
    .command_i  (s_axis_tuser),
    .start_x_i  (s_axis_tdata[COORD_BITS-1:0]),
    .start_y_i  (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .finish_x_i (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .finish_y_i (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .ld_o       (ld),
    .cur_x_o    (cur_x),
    .cur_y_o    (cur_y),
    .done_o     (done)
  );

  tlr_pen #(
    .COORD_BITS    (COORD_BITS),
    .MAX_THICKNESS (MAX_THICKNESS)
  ) u_pen (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ld_i            (ld),
    .cur_x_i         (cur_x),
    .cur_y_i         (cur_y),
    .done_i          (done),
    .cfg_i           (cfg_q),
    .take_o          (take),
    .valid_o         (m_axis_tvalid),
    .ready_i         (m_axis_tready),
    .pixel_x_o       (pixel_x),
    .pixel_y_o       (pixel_y),
    .byte_index_o    (byte_index),
    .red_o           (red),
    .green_o         (green),
    .blue_o          (blue),
    .write_enable_o  (write_enable),
    .last_of_point_o (last_of_point),
    .line_done_o     (line_done)
  );

  assign s_axis_tready = take;

  assign m_axis_tdata = OutDataW'({blue, green, red, byte_index, pixel_y, pixel_x});
  assign m_axis_tuser = {line_done, write_enable};
  assign m_axis_tlast = last_of_point;

endmodule

>>> rtl/core/tlr_step.sv
// ----------------------------------------------------------------------------
// tlr_step
// Bresenham walker: line set-up on start, one step per advance until the end.
// ----------------------------------------------------------------------------
module tlr_step #(
  parameter int unsigned COORD_BITS = tlr_pkg::TlrCoordBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic                         take_i,
  input  logic                         command_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] finish_x_i,
  input  logic signed [COORD_BITS-1:0] finish_y_i,
  output tlr_pkg::tlr_load_t           ld_o,
  output logic signed [COORD_BITS-1:0] cur_x_o,
  output logic signed [COORD_BITS-1:0] cur_y_o,
  output logic                         done_o
);
  import tlr_pkg::*;

  localparam int unsigned DW  = COORD_BITS + 1;
  localparam int unsigned EW  = COORD_BITS + 2;
  localparam int unsigned E2W = COORD_BITS + 3;

  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [COORD_BITS-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [COORD_BITS-1:0]        dx_q, dx_d, dy_q, dy_d;
  logic                         neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic signed [EW-1:0]         err_q, err_d;
  logic                         fin_q, fin_d;

  logic                         accept;
  logic                         is_start;
  logic signed [DW-1:0]         diff_x, diff_y;
  logic signed [E2W-1:0]        e2, err_w, dx_w, dy_w;
  logic                         move_x, move_y;

  assign accept   = valid_i && take_i;
  assign is_start = (tlr_cmd_e'(command_i) == CMD_START);

  assign diff_x = DW'(finish_x_i) - DW'(start_x_i);
  assign diff_y = DW'(finish_y_i) - DW'(start_y_i);

  assign dx_w   = $signed({3'b000, dx_q});
  assign dy_w   = $signed({3'b000, dy_q});
  assign e2     = {err_q, 1'b0};
  assign move_x = e2 > -dy_w;
  assign move_y = e2 < dx_w;

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    tgt_x_d = tgt_x_q;
    tgt_y_d = tgt_y_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    neg_x_d = neg_x_q;
    neg_y_d = neg_y_q;
    err_d   = err_q;
    err_w   = E2W'(err_q);
    if (is_start) begin
      cur_x_d = start_x_i;
      cur_y_d = start_y_i;
      tgt_x_d = finish_x_i;
      tgt_y_d = finish_y_i;
      dx_d    = diff_x[DW-1] ? COORD_BITS'(-diff_x) : COORD_BITS'(diff_x);
      dy_d    = diff_y[DW-1] ? COORD_BITS'(-diff_y) : COORD_BITS'(diff_y);
      neg_x_d = !(start_x_i < finish_x_i);
      neg_y_d = !(start_y_i < finish_y_i);
      err_d   = $signed({2'b00, dx_d}) - $signed({2'b00, dy_d});
    end else if (!fin_q) begin
      if (move_x) begin
        err_w   = err_w - dy_w;
        cur_x_d = neg_x_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
      end
      if (move_y) begin
        err_w   = err_w + dx_w;
        cur_y_d = neg_y_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
      end
      err_d = EW'(err_w);
    end
    fin_d = (cur_x_d == tgt_x_d) && (cur_y_d == tgt_y_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      tgt_x_q <= '0;
      tgt_y_q <= '0;
      dx_q    <= '0;
      dy_q    <= '0;
      neg_x_q <= 1'b0;
      neg_y_q <= 1'b0;
      err_q   <= '0;
      fin_q   <= 1'b1;
    end else if (accept) begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      tgt_x_q <= tgt_x_d;
      tgt_y_q <= tgt_y_d;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      neg_x_q <= neg_x_d;
      neg_y_q <= neg_y_d;
      err_q   <= err_d;
      fin_q   <= fin_d;
    end
  end

  assign ld_o.load  = accept;
  assign ld_o.empty = !is_start && fin_q;
  assign cur_x_o    = cur_x_q;
  assign cur_y_o    = cur_y_q;
  assign done_o     = fin_q;

endmodule

>>> rtl/core/tlr_pen.sv
// ----------------------------------------------------------------------------
// tlr_pen
// Pen square sequencer: one pixel per cycle into the result register, unless stalled.
// ----------------------------------------------------------------------------
module tlr_pen #(
  parameter int unsigned COORD_BITS    = tlr_pkg::TlrCoordBits,
  parameter int unsigned MAX_THICKNESS = tlr_pkg::TlrMaxThick
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tlr_pkg::tlr_load_t                   ld_i,
  input  logic signed [COORD_BITS-1:0]         cur_x_i,
  input  logic signed [COORD_BITS-1:0]         cur_y_i,
  input  logic                                 done_i,
  input  tlr_pkg::tlr_cfg_t                    cfg_i,
  output logic                                 take_o,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [COORD_BITS:0]           pixel_x_o,
  output logic signed [COORD_BITS:0]           pixel_y_o,
  output logic [tlr_pkg::IdxBits-1:0]          byte_index_o,
  output logic [tlr_pkg::ColourBits-1:0]       red_o,
  output logic [tlr_pkg::ColourBits-1:0]       green_o,
  output logic [tlr_pkg::ColourBits-1:0]       blue_o,
  output logic                                 write_enable_o,
  output logic                                 last_of_point_o,
  output logic                                 line_done_o
);
  import tlr_pkg::*;

  localparam int unsigned PW      = COORD_BITS + 1;
  localparam int unsigned MaxHalf = MAX_THICKNESS / 2;
  localparam int unsigned SqBits  = (MaxHalf == 0) ? 1 : $clog2(2 * MaxHalf + 1);

  logic                 busy_q;
  logic                 empty_q;
  logic [SqBits-1:0]    tx_q, ty_q;
  logic                 ovalid_q;

  logic signed [PW-1:0]  pixel_x_q, pixel_y_q;
  logic [IdxBits-1:0]    byte_index_q;
  logic [ColourBits-1:0] red_q, green_q, blue_q;
  logic                  write_enable_q, last_of_point_q, line_done_q;

  logic [ThickBits-1:0] th;
  logic [SqBits-1:0]    half, span;
  logic signed [SqBits:0] off_x, off_y;
  logic signed [PW-1:0] px, py;
  logic                 en;
  logic [IdxBits-1:0]   row_off, lin, idx;
  logic                 adv, last;

  assign th   = (cfg_i.thick > ThickBits'(MAX_THICKNESS)) ? ThickBits'(MAX_THICKNESS)
                                                          : cfg_i.thick;
  assign half = SqBits'(th >> 1);
  assign span = SqBits'({half, 1'b0});

  assign adv    = busy_q && (!ovalid_q || ready_i);
  assign last   = empty_q || ((tx_q == span) && (ty_q == span));
  assign take_o = !busy_q || (adv && last);

  assign off_x = $signed({1'b0, tx_q}) - $signed({1'b0, half});
  assign off_y = $signed({1'b0, ty_q}) - $signed({1'b0, half});
  assign px = {cur_x_i[COORD_BITS-1], cur_x_i}
            + {{(PW-SqBits-1){off_x[SqBits]}}, off_x};
  assign py = {cur_y_i[COORD_BITS-1], cur_y_i}
            + {{(PW-SqBits-1){off_y[SqBits]}}, off_y};

  assign en = !px[PW-1] && !py[PW-1] &&
              (px[PW-2:0] < cfg_i.width) && (py[PW-2:0] < cfg_i.height);

  // (y*w + x)*3, wrapping at the index width
  assign row_off = IdxBits'(py[PW-2:0]) * IdxBits'(cfg_i.width);
  assign lin     = row_off + IdxBits'(px[PW-2:0]);
  assign idx     = lin + {lin[IdxBits-2:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      empty_q <= 1'b0;
      tx_q    <= '0;
      ty_q    <= '0;
    end else if (ld_i.load) begin
      busy_q  <= 1'b1;
      empty_q <= ld_i.empty;
      tx_q    <= '0;
      ty_q    <= '0;
    end else if (adv) begin
      if (last) begin
        busy_q <= 1'b0;
      end else if (ty_q == span) begin
        ty_q <= '0;
        tx_q <= tx_q + 1'b1;
      end else begin
        ty_q <= ty_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (adv) begin
      ovalid_q <= 1'b1;
    end else if (ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (empty_q) begin
        pixel_x_q      <= '0;
        pixel_y_q      <= '0;
        byte_index_q   <= '0;
        red_q          <= '0;
        green_q        <= '0;
        blue_q         <= '0;
        write_enable_q <= 1'b0;
        line_done_q    <= 1'b1;
      end else begin
        pixel_x_q      <= px;
        pixel_y_q      <= py;
        byte_index_q   <= en ? idx : '0;
        red_q          <= cfg_i.red;
        green_q        <= cfg_i.green;
        blue_q         <= cfg_i.blue;
        write_enable_q <= en;
        line_done_q    <= done_i;
      end
      last_of_point_q <= last;
    end
  end

  assign valid_o         = ovalid_q;
  assign pixel_x_o       = pixel_x_q;
  assign pixel_y_o       = pixel_y_q;
  assign byte_index_o    = byte_index_q;
  assign red_o           = red_q;
  assign green_o         = green_q;
  assign blue_o          = blue_q;
  assign write_enable_o  = write_enable_q;
  assign last_of_point_o = last_of_point_q;
  assign line_done_o     = line_done_q;

`ifndef SYNTHESIS
  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_i.load |-> take_o)
    else $error("point loaded while pen square still running");

  a_empty_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && empty_q) |-> (tx_q == '0 && ty_q == '0))
    else $error("blank result sequence moved its counters");

  a_counter_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (tx_q <= span && ty_q <= span))
    else $error("pen offset outside square");

  a_clip_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !write_enable_q) |-> (byte_index_q == '0))
    else $error("clipped pixel carries a byte index");

  a_last_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last && !ld_i.load) |=> !busy_q)
    else $error("sequencer stayed busy after final pixel");
`endif

endmodule
